// ===== hw/rtl/auto_ranging_level_meter_defines.svh =====
// ============================================================================
// Assertion macros for the level meter
// Shared concurrent-assertion wrappers; they compile to nothing in synthesis.
// ============================================================================
`ifndef AUTO_RANGING_LEVEL_METER_DEFINES_SVH
`define AUTO_RANGING_LEVEL_METER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define ARLM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ARLM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ARLM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ARLM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/arlm_pkg.sv =====
// ============================================================================
// Level meter package
// Shared widths, reset values, register indexes, item layouts, controller
// states and the command and status bundles between controller and datapath.
// ============================================================================
package arlm_pkg;

    // Default geometry of the LED strip and the matrix display.
    localparam int LED_COUNT_DEF   = 300;
    localparam int MATRIX_ROWS_DEF = 8;

    // Fixed field widths.
    localparam int SAMPLE_W = 10;
    localparam int IDLE_H_W = 9;
    localparam int AMP_W    = 13;
    localparam int CEIL_W   = 13;
    localparam int BAR_W    = 9;
    localparam int PEAK_W   = 9;
    localparam int ROWS_W   = 4;
    localparam int HUE_W    = 8;

    // Configuration register widths.
    localparam int ZP_W   = 10;
    localparam int GAIN_W = 3;
    localparam int GATE_W = 8;
    localparam int MINC_W = 10;
    localparam int THR_W  = 10;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POINT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CEILING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_THRESH  = 3'd4;

    // Register reset values.
    localparam logic [ZP_W-1:0]   ZERO_POINT_RST = 10'd512;
    localparam logic [GAIN_W-1:0] GAIN_RST       = 3'd3;
    localparam logic [GATE_W-1:0] GATE_RST       = 8'd15;
    localparam logic [MINC_W-1:0] MIN_CEIL_RST   = 10'd120;
    localparam logic [THR_W-1:0]  THR_RST        = 10'd50;

    // Ceiling value after reset and in idle mode.
    localparam logic [CEIL_W-1:0] CEIL_IDLE = 13'd100;

    // Stream data widths.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    // Input item, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]          pad;
        logic [IDLE_H_W-1:0] idle_height;
        logic                peak_tick;
        logic                ceiling_tick;
        logic                music_switch;
        logic [SAMPLE_W-1:0] sample;
    } t_s_item;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [6:0]        pad;
        logic              music_active;
        logic [HUE_W-1:0]  hue_base;
        logic [ROWS_W-1:0] matrix_rows;
        logic [PEAK_W-1:0] peak_pos;
        logic [BAR_W-1:0]  bar_height;
        logic [CEIL_W-1:0] ceiling;
        logic [AMP_W-1:0]  amplitude;
    } t_m_item;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AMP,
        ST_CEIL,
        ST_DIV,
        ST_HGT,
        ST_PEAK,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic amp_en;
        logic ceil_en;
        logic div_step;
        logic hgt_en;
        logic peak_en;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
    } t_dp_stat;

endpackage

// ===== hw/rtl/arlm_ctrl.sv =====
// ============================================================================
// Level meter controller
// Sequences one item through amplitude, ceiling, division, height and peak
// steps (idle items skip from amplitude to peak) and owns the result valid flag.
// ============================================================================
`include "auto_ranging_level_meter_defines.svh"

module arlm_ctrl #(
    parameter int LED_COUNT = arlm_pkg::LED_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    input  arlm_pkg::t_dp_stat i_stat,
    output arlm_pkg::t_dp_cmd  o_cmd
);
    import arlm_pkg::*;

    // Quotient bits produced by the divider, one per cycle.
    localparam int QW    = $clog2(2 * LED_COUNT + 1);
    localparam int CNT_W = $clog2(QW);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_out_valid;
    logic               n_out_valid;
    t_dp_cmd            w_cmd;

    // State, step counter and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = ST_AMP;
                end
            end
            ST_AMP: begin
                w_cmd.amp_en = 1'b1;
                n_state      = i_stat.active ? ST_CEIL : ST_PEAK;
            end
            ST_CEIL: begin
                w_cmd.ceil_en = 1'b1;
                n_cnt         = CNT_W'(QW - 1);
                n_state       = ST_DIV;
            end
            ST_DIV: begin
                w_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_HGT;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_HGT: begin
                w_cmd.hgt_en = 1'b1;
                n_state      = ST_PEAK;
            end
            ST_PEAK: begin
                w_cmd.peak_en = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The result register fills on a load and empties on a transfer.
    always_comb begin
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;
    assign o_cmd     = w_cmd;

    // A waiting result is only replaced in the cycle it is taken.
    `ARLM_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load && r_out_valid, i_m_ready, "result overwritten before transfer")
    // The divider runs exactly its step count before the height update.
    `ARLM_ASSERT_NXT(a_div_end, i_clk, i_rst_n, (r_state == ST_DIV) && (r_cnt == '0), r_state == ST_HGT, "divider did not finish into height step")
    // An accepted item starts the amplitude step and blocks further input.
    `ARLM_ASSERT_NXT(a_accept_start, i_clk, i_rst_n, i_s_valid && o_s_ready, (r_state == ST_AMP) && !o_s_ready, "accepted item did not start processing")

endmodule

// ===== hw/rtl/arlm_dp.sv =====
// ============================================================================
// Level meter datapath
// Configuration registers, meter state, amplitude and ceiling logic, a
// shift-subtract divider for bar scaling, smoothing, peak hold and the
// result register.
// ============================================================================
`include "auto_ranging_level_meter_defines.svh"

module arlm_dp #(
    parameter int LED_COUNT   = arlm_pkg::LED_COUNT_DEF,
    parameter int MATRIX_ROWS = arlm_pkg::MATRIX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [arlm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [arlm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  arlm_pkg::t_s_item               i_s_item,
    input  arlm_pkg::t_dp_cmd               i_cmd,
    output arlm_pkg::t_dp_stat              o_stat,
    output arlm_pkg::t_m_item               o_m_item
);
    import arlm_pkg::*;

    localparam int HW = $clog2(LED_COUNT + 1);
    localparam int QW = $clog2(2 * LED_COUNT + 1);
    localparam int PW = CEIL_W + HW;
    localparam int RW = $clog2(MATRIX_ROWS + 1);
    localparam int MW = HW + RW;
    localparam int CW = ((HW > IDLE_H_W) ? HW : IDLE_H_W) + 1;
    localparam int SW = HW + 4;

    localparam logic [HW-1:0] LED_N   = HW'(LED_COUNT);
    localparam logic [HW-1:0] LED_TOP = HW'(LED_COUNT - 1);

    // Configuration registers.
    logic [ZP_W-1:0]     r_zero_point;
    logic [GAIN_W-1:0]   r_gain;
    logic [GATE_W-1:0]   r_gate;
    logic [MINC_W-1:0]   r_min_ceil;
    logic [THR_W-1:0]    r_thr;

    // Captured input item.
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_music;
    logic                r_ctick;
    logic                r_ptick;
    logic [IDLE_H_W-1:0] r_idle_h;

    // Meter state.
    logic [HW-1:0]       r_height;
    logic [HW-1:0]       r_peak;
    logic [CEIL_W-1:0]   r_ceil;
    logic [HUE_W-1:0]    r_hue;

    // Working registers.
    logic [AMP_W-1:0]    r_amp;
    logic                r_active;
    logic [PW-1:0]       r_rem;
    logic [PW-1:0]       r_dsh;
    logic [QW-1:0]       r_quo;
    logic [RW-1:0]       r_rows;
    t_m_item             r_out;

    logic                w_active;
    logic [SAMPLE_W-1:0] w_dev;
    logic [AMP_W-1:0]    w_prod;
    logic [AMP_W-1:0]    w_amp;
    logic [HW-1:0]       w_idle_h;
    logic [CEIL_W-1:0]   w_ceil_max;
    logic [CEIL_W-1:0]   n_ceil;
    logic [PW-1:0]       w_num;
    logic                w_ge;
    logic [HW-1:0]       w_target;
    logic [SW-1:0]       w_sum;
    logic [HW-1:0]       n_height;
    logic [HW-1:0]       w_peak_up;
    logic [HW-1:0]       n_peak;
    logic [RW-1:0]       n_rows;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_point <= ZERO_POINT_RST;
            r_gain       <= GAIN_RST;
            r_gate       <= GATE_RST;
            r_min_ceil   <= MIN_CEIL_RST;
            r_thr        <= THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ZERO_POINT:  r_zero_point <= i_cfg_data[ZP_W-1:0];
                CFG_GAIN:        r_gain       <= i_cfg_data[GAIN_W-1:0];
                CFG_NOISE_GATE:  r_gate       <= i_cfg_data[GATE_W-1:0];
                CFG_MIN_CEILING: r_min_ceil   <= i_cfg_data[MINC_W-1:0];
                CFG_ACT_THRESH:  r_thr        <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Input capture on acceptance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_s_item.sample;
            r_music  <= i_s_item.music_switch;
            r_ctick  <= i_s_item.ceiling_tick;
            r_ptick  <= i_s_item.peak_tick;
            r_idle_h <= i_s_item.idle_height;
        end
    end

    // Music branch is taken only for a sample above the threshold.
    assign w_active      = r_music && (r_sample > r_thr);
    assign o_stat.active = w_active;

    // Gained absolute deviation with noise gate.
    assign w_dev  = (r_sample >= r_zero_point) ? (r_sample - r_zero_point)
                                               : (r_zero_point - r_sample);
    assign w_prod = AMP_W'(w_dev) * AMP_W'(r_gain);
    assign w_amp  = (w_prod < AMP_W'(r_gate)) ? '0 : w_prod;

    // Idle height limited to the last LED.
    assign w_idle_h = (CW'(r_idle_h) > CW'(LED_COUNT - 1)) ? LED_TOP : HW'(r_idle_h);

    // Ceiling follows louder amplitudes and decays one step per tick.
    assign w_ceil_max = (r_amp > r_ceil) ? r_amp : r_ceil;
    assign n_ceil     = (r_ctick && (w_ceil_max > CEIL_W'(r_min_ceil)))
                        ? (w_ceil_max - CEIL_W'(1)) : w_ceil_max;

    // Dividend for the bar scaling.
    assign w_num = PW'(r_amp) * PW'(LED_N);

    // One quotient bit per divider step.
    assign w_ge = (r_rem >= r_dsh);

    // Bar target saturates at the strip length; a zero ceiling gives zero.
    assign w_target = (r_ceil == '0) ? '0
                    : (r_quo > QW'(LED_COUNT)) ? LED_N : HW'(r_quo);

    // Rise at once, fall as (15h + t) / 16.
    assign w_sum    = (SW'(r_height) << 4) - SW'(r_height) + SW'(w_target);
    assign n_height = (w_target > r_height) ? w_target : HW'(w_sum >> 4);

    // Peak follows the bar up and falls one LED per tick.
    always_comb begin
        if (r_height > r_peak) begin
            w_peak_up = r_height;
        end else if (r_ptick && (r_peak != '0)) begin
            w_peak_up = r_peak - HW'(1);
        end else begin
            w_peak_up = r_peak;
        end
    end
    assign n_peak = (w_peak_up > LED_TOP) ? LED_TOP : w_peak_up;

    // Matrix rows: the highest row count whose threshold the bar reaches.
    always_comb begin
        n_rows = '0;
        for (int k = 1; k <= MATRIX_ROWS; k++) begin
            if (MW'(r_height) * MW'(MATRIX_ROWS) >= MW'(k * LED_COUNT)) begin
                n_rows = RW'(k);
            end
        end
    end

    // Meter state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= '0;
            r_peak   <= '0;
            r_ceil   <= CEIL_IDLE;
            r_hue    <= '0;
        end else begin
            if (i_cmd.amp_en && !w_active) begin
                r_height <= w_idle_h;
                r_peak   <= w_idle_h;
                r_ceil   <= CEIL_IDLE;
            end
            if (i_cmd.ceil_en) begin
                r_ceil <= n_ceil;
            end
            if (i_cmd.hgt_en) begin
                r_height <= n_height;
                r_hue    <= r_hue + HUE_W'(1);
            end
            if (i_cmd.peak_en && r_active) begin
                r_peak <= n_peak;
            end
        end
    end

    // Amplitude, divider and row count working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.amp_en) begin
            r_amp    <= w_active ? w_amp : '0;
            r_active <= w_active;
        end
        if (i_cmd.ceil_en) begin
            r_rem <= w_num;
            r_dsh <= PW'(n_ceil) << (QW - 1);
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? (r_rem - r_dsh) : r_rem;
            r_dsh <= r_dsh >> 1;
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
        if (i_cmd.peak_en) begin
            r_rows <= n_rows;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.pad          <= '0;
            r_out.music_active <= r_active;
            r_out.hue_base     <= r_hue;
            r_out.matrix_rows  <= ROWS_W'(r_rows);
            r_out.peak_pos     <= PEAK_W'(r_peak);
            r_out.bar_height   <= BAR_W'(r_height);
            r_out.ceiling      <= r_ceil;
            r_out.amplitude    <= r_amp;
        end
    end

    assign o_m_item = r_out;

    // The peak dot never leaves the strip.
    `ARLM_ASSERT_IMP(a_peak_range, i_clk, i_rst_n, 1'b1, r_peak <= LED_TOP, "peak beyond last LED")
    // The bar never exceeds the strip length.
    `ARLM_ASSERT_IMP(a_height_range, i_clk, i_rst_n, 1'b1, r_height <= LED_N, "bar beyond strip length")
    // Idle mode returns the ceiling to its resting value.
    `ARLM_ASSERT_NXT(a_idle_ceiling, i_clk, i_rst_n, i_cmd.amp_en && !w_active, r_ceil == CEIL_IDLE, "idle did not restore ceiling")

endmodule

// ===== hw/rtl/auto_ranging_level_meter.sv =====
// ============================================================================
// Auto-ranging level meter
// Level meter with self-adjusting ceiling, smoothed bar and peak hold.
// ============================================================================
// Usage:
// - Input stream (s_axis_*): one audio sample per transfer with the mode
//   switch, the two decay ticks and the idle height. A transfer completes
//   when tvalid and tready are both high at a rising clock edge.
// - Output stream (m_axis_*): one result per input, in order.
// - Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 zero point, 1 gain, 2 noise gate, 3 minimum ceiling, 4 activity
//   threshold). Write only while no item is in flight.
// - Timing: an item in music mode runs from acceptance to a valid result
//   through the amplitude, ceiling, division, height, peak and output steps;
//   the shift-subtract divider that scales the amplitude to the bar yields one
//   quotient bit per cycle. An idle item skips the ceiling, division and height
//   steps. The next item is accepted in the cycle after the previous result is
//   loaded, so no new item is taken while one is being computed.
// - Stalls: the result register holds one result while the receiver is not
//   ready; a following item is still accepted and computed, and waits in its
//   last step until the register is free.
// - Reset (synchronous, active low): registers return to their defaults,
//   ceiling 100, bar, peak and hue zero, no result pending.
// ============================================================================
module auto_ranging_level_meter #(
    parameter int LED_COUNT   = arlm_pkg::LED_COUNT_DEF,
    parameter int MATRIX_ROWS = arlm_pkg::MATRIX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sample[9:0], music_switch[10], ceiling_tick[11], peak_tick[12],
    // idle_height[21:13], zero[23:22]
    input  logic [arlm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // amplitude[12:0], ceiling[25:13], bar_height[34:26], peak_pos[43:35],
    // matrix_rows[47:44], hue_base[55:48], music_active[56], zero[63:57]
    output logic [arlm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [arlm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [arlm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import arlm_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_s_item  w_s_item;
    t_m_item  w_m_item;

    assign w_s_item     = s_axis_tdata;
    assign m_axis_tdata = w_m_item;

    // Sequencer.
    arlm_ctrl #(
        .LED_COUNT (LED_COUNT)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // Arithmetic and state.
    arlm_dp #(
        .LED_COUNT   (LED_COUNT),
        .MATRIX_ROWS (MATRIX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_item    (w_s_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_m_item    (w_m_item)
    );

endmodule
